// ----- sv/fsa_pkg.sv -----
// shared constants and types for the forth stack alu
package fsa_pkg;
	localparam int DataDepthDef = 64;
	localparam int AuxDepthDef = 64;

	localparam logic [4:0] OP_LIT = 5'd0;
	localparam logic [4:0] OP_DROP = 5'd1;
	localparam logic [4:0] OP_DUP = 5'd2;
	localparam logic [4:0] OP_SWAP = 5'd3;
	localparam logic [4:0] OP_ADD = 5'd4;
	localparam logic [4:0] OP_SUB = 5'd5;
	localparam logic [4:0] OP_MUL = 5'd6;
	localparam logic [4:0] OP_DIV = 5'd7;
	localparam logic [4:0] OP_MOD = 5'd8;
	localparam logic [4:0] OP_EQ = 5'd9;
	localparam logic [4:0] OP_LT = 5'd10;
	localparam logic [4:0] OP_GT = 5'd11;
	localparam logic [4:0] OP_NOT = 5'd12;
	localparam logic [4:0] OP_AND = 5'd13;
	localparam logic [4:0] OP_OR = 5'd14;
	localparam logic [4:0] OP_XOR = 5'd15;
	localparam logic [4:0] OP_POP = 5'd16;
	localparam logic [4:0] OP_TOAUX = 5'd17;
	localparam logic [4:0] OP_FROMAUX = 5'd18;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER = 2'd2;
	localparam logic [1:0] ST_DIVZ = 2'd3;

	typedef struct packed {
		logic [4:0] opcode;
		logic [31:0] literal;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] top_value;
		logic [31:0] popped_value;
		logic [6:0] data_depth;
		logic [6:0] aux_depth;
	} res_t;
endpackage

// ----- sv/fsa_if.sv -----
// valid/ready channel carrying one word
interface fsa_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ----- sv/forth_stack_alu_unit.sv -----
// forth stack alu: two stack memories, read-modify-write sequencer
// steps: memory read, execute/write, output; swap adds a second write, mul a multiply
// step, and div and mod a bit-serial divide step when the divisor is nonzero.
// one word at a time, taken only when idle; an unread result stalls the next in execute.
// reset: pointers cleared, stack memories not cleared; result register empty.
module forth_stack_alu_unit #(
	parameter int DATA_DEPTH = fsa_pkg::DataDepthDef,
	parameter int AUX_DEPTH = fsa_pkg::AuxDepthDef
) (
	input logic clk,
	input logic arst_n,
	fsa_if.sink in_ch,
	fsa_if.source out_ch
);
	import fsa_pkg::*;

	localparam int DW = $clog2(DATA_DEPTH + 1);
	localparam int AW = $clog2(AUX_DEPTH + 1);
	localparam int DIW = $clog2(DATA_DEPTH);
	localparam int AIW = $clog2(AUX_DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_MUL = 3'd3;
	localparam logic [2:0] S_DIV = 3'd4;
	localparam logic [2:0] S_WR2 = 3'd5;
	localparam logic [2:0] S_OUT = 3'd6;

	logic [31:0] dmem [DATA_DEPTH];
	logic [31:0] amem [AUX_DEPTH];

	logic [2:0] state_q;
	logic [DW-1:0] dp_q;
	logic [AW-1:0] ap_q;
	logic [4:0] op_q;
	logic [31:0] lit_q;
	logic [31:0] t_q, n_q, a_q;
	logic [31:0] rd_t, rd_n, rd_a;
	logic [31:0] quo_q, rem_q, mul_q;
	logic [5:0] cnt_q;
	logic [DIW-1:0] wr2_addr_q;
	logic [31:0] wr2_data_q;
	logic out_valid_q;
	res_t res_q;
	logic [DIW-1:0] ra_t, ra_n;
	logic [AIW-1:0] ra_a;
	logic out_free;

	logic d_we;
	logic [DIW-1:0] d_wa;
	logic [31:0] d_wd;
	logic a_we;
	logic [AIW-1:0] a_wa;
	logic [31:0] a_wd;

	// read addresses for top, next and aux top
	always_comb begin
		ra_t = (dp_q == '0) ? '0 : DIW'(dp_q - DW'(1));
		ra_n = (dp_q < DW'(2)) ? '0 : DIW'(dp_q - DW'(2));
		ra_a = (ap_q == '0) ? '0 : AIW'(ap_q - AW'(1));
	end

	// two read ports on data memory via two banked copies of the same contents
	logic [31:0] dmem2 [DATA_DEPTH];
	always_ff @(posedge clk) begin
		if (d_we) begin
			dmem[d_wa] <= d_wd;
			dmem2[d_wa] <= d_wd;
		end
		if (a_we) amem[a_wa] <= a_wd;
		rd_t <= dmem[ra_t];
		rd_n <= dmem2[ra_n];
		rd_a <= amem[ra_a];
	end

	logic [32:0] div_sub;
	assign div_sub = {rem_q, quo_q[31]} - {1'b0, t_q};

	logic dfull, afull;
	logic [1:0] st;
	logic [DW-1:0] dp_n;
	logic [AW-1:0] ap_n;
	logic [31:0] res_v, pop_v;
	logic binop;

	always_comb begin
		dfull = dp_q >= DW'(DATA_DEPTH);
		afull = ap_q >= AW'(AUX_DEPTH);
		binop = (op_q >= OP_ADD && op_q <= OP_XOR && op_q != OP_NOT);
		st = ST_OK;
		unique case (op_q)
			OP_LIT: if (dfull) st = ST_OVER;
			OP_DROP, OP_NOT, OP_POP: if (dp_q < DW'(1)) st = ST_UNDER;
			OP_DUP: begin
				if (dp_q < DW'(1)) st = ST_UNDER;
				else if (dfull) st = ST_OVER;
			end
			OP_SWAP: if (dp_q < DW'(2)) st = ST_UNDER;
			OP_TOAUX: begin
				if (dp_q < DW'(1)) st = ST_UNDER;
				else if (afull) st = ST_OVER;
			end
			OP_FROMAUX: begin
				if (ap_q < AW'(1)) st = ST_UNDER;
				else if (dfull) st = ST_OVER;
			end
			default: begin
				if (binop) begin
					if (dp_q < DW'(2)) st = ST_UNDER;
					else if ((op_q == OP_DIV || op_q == OP_MOD) && t_q == '0) st = ST_DIVZ;
				end
			end
		endcase
		unique case (op_q)
			OP_EQ: res_v = {31'd0, n_q == t_q};
			OP_LT: res_v = {31'd0, n_q < t_q};
			OP_GT: res_v = {31'd0, n_q > t_q};
			OP_ADD: res_v = n_q + t_q;
			OP_SUB: res_v = n_q - t_q;
			OP_AND: res_v = n_q & t_q;
			OP_OR: res_v = n_q | t_q;
			OP_MUL: res_v = mul_q;
			OP_DIV: res_v = quo_q;
			OP_MOD: res_v = rem_q;
			default: res_v = n_q ^ t_q;
		endcase
		pop_v = '0;
		dp_n = dp_q;
		ap_n = ap_q;
		if (st == ST_OK) begin
			unique case (op_q)
				OP_LIT, OP_DUP, OP_FROMAUX: dp_n = dp_q + DW'(1);
				OP_DROP: dp_n = dp_q - DW'(1);
				OP_POP: begin
					dp_n = dp_q - DW'(1);
					pop_v = t_q;
				end
				OP_TOAUX: begin
					dp_n = dp_q - DW'(1);
					ap_n = ap_q + AW'(1);
				end
				default: if (binop) dp_n = dp_q - DW'(1);
			endcase
			if (op_q == OP_FROMAUX) ap_n = ap_q - AW'(1);
		end
		d_we = 1'b0;
		d_wa = ra_t;
		d_wd = res_v;
		a_we = 1'b0;
		a_wa = AIW'(ap_q);
		a_wd = t_q;
		if (state_q == S_EXEC && st == ST_OK) begin
			unique case (op_q)
				OP_LIT: begin
					d_we = 1'b1;
					d_wa = DIW'(dp_q);
					d_wd = lit_q;
				end
				OP_DUP: begin
					d_we = 1'b1;
					d_wa = DIW'(dp_q);
					d_wd = t_q;
				end
				OP_FROMAUX: begin
					d_we = 1'b1;
					d_wa = DIW'(dp_q);
					d_wd = a_q;
				end
				OP_SWAP: begin
					d_we = 1'b1;
					d_wa = ra_t;
					d_wd = n_q;
				end
				OP_NOT: begin
					d_we = 1'b1;
					d_wa = ra_t;
					d_wd = {31'd0, t_q == '0};
				end
				OP_TOAUX: a_we = 1'b1;
				default: begin
					if (binop) begin
						d_we = 1'b1;
						d_wa = ra_n;
					end
				end
			endcase
		end else if (state_q == S_WR2) begin
			d_we = 1'b1;
			d_wa = wr2_addr_q;
			d_wd = wr2_data_q;
		end
	end

	// new top after the step
	logic [31:0] top_v;
	always_comb begin
		top_v = '0;
		if (dp_n != '0) begin
			if (st != ST_OK) top_v = t_q;
			else begin
				unique case (op_q)
					OP_LIT: top_v = lit_q;
					OP_DUP: top_v = t_q;
					OP_FROMAUX: top_v = a_q;
					OP_SWAP: top_v = n_q;
					OP_NOT: top_v = {31'd0, t_q == '0};
					OP_DROP, OP_POP, OP_TOAUX: top_v = n_q;
					default: top_v = binop ? res_v : t_q;
				endcase
			end
		end
	end

	assign out_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dp_q <= '0;
			ap_q <= '0;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_ch.valid && in_ch.ready) state_q <= S_READ;
				S_READ: begin
					cnt_q <= '0;
					if (op_q == OP_MUL) state_q <= S_MUL;
					else if ((op_q == OP_DIV || op_q == OP_MOD) && dp_q >= DW'(2) && rd_t != '0)
						state_q <= S_DIV;
					else state_q <= S_EXEC;
				end
				S_MUL: state_q <= S_EXEC;
				S_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) state_q <= S_EXEC;
				end
				S_EXEC: begin
					// hold until the result register is free
					if (out_free) begin
						dp_q <= dp_n;
						ap_q <= ap_n;
						res_q <= '{st, top_v, pop_v, 7'(dp_n), 7'(ap_n)};
						if (op_q == OP_SWAP && st == ST_OK) state_q <= S_WR2;
						else state_q <= S_OUT;
					end
				end
				S_WR2: state_q <= S_OUT;
				S_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			op_q <= in_ch.payload.opcode;
			lit_q <= in_ch.payload.literal;
		end
		if (state_q == S_READ) begin
			t_q <= rd_t;
			n_q <= rd_n;
			a_q <= rd_a;
			quo_q <= rd_n;
			rem_q <= '0;
		end
		if (state_q == S_MUL) mul_q <= n_q * t_q;
		if (state_q == S_DIV) begin
			if (!div_sub[32]) rem_q <= div_sub[31:0];
			else rem_q <= {rem_q[30:0], quo_q[31]};
			quo_q <= {quo_q[30:0], !div_sub[32]};
		end
		if (state_q == S_EXEC) begin
			wr2_addr_q <= ra_n;
			wr2_data_q <= t_q;
		end
	end
endmodule
